### hdl/plru_pkg.sv
// Shared types and constants for the page replacement unit.
// No dependencies; used by plru_cell and page_replacement_lru_clock_unit.
`default_nettype none
package plru_pkg;

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_SUB   = 2'd1,
        OP_WRITE = 2'd2,
        OP_READ  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        CFG_POLICY = 2'd0,
        CFG_FRAMES = 2'd1,
        CFG_OFFSET = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE
    } t_state;

    localparam logic POLICY_LRU   = 1'b0;
    localparam logic POLICY_CLOCK = 1'b1;

    localparam logic [31:0] OP_MASK    = 32'h0000_00C0;
    localparam logic [31:0] VALUE_MASK = 32'h0000_003F;
    localparam int          OP_LSB     = 6;

    typedef struct packed {
        logic valid;
        logic refb;
        logic dirty;
    } t_slot_flags;

    typedef struct packed {
        logic fill;
        logic fill_dirty;
        logic shift;
        logic clr_ref;
        logic set_ref;
        logic set_dirty;
    } t_cell_ctl;

endpackage
`default_nettype wire

### hdl/page_replacement_lru_clock_unit.sv
// Page replacement unit: LRU recency stack or second-chance clock over a chain of slots.
// Depends on plru_pkg and plru_cell.
//
//  channel  signals                               role
//  in       i_in_valid/o_in_ready, reference_word  one memory reference per beat
//  out      o_out_valid/i_out_ready, result fields one result per reference
//  cfg      i_cfg_we, i_cfg_index, i_cfg_data      register write, no handshake
//
// The slot compare for a reference is registered on acceptance; the chain update and
// result register load follow in the update state, once the result register is free.
// A pending result that is not taken holds the update cycle.
// Synchronous active-low reset clears all marks, counts and the accumulator.
`default_nettype none
module page_replacement_lru_clock_unit #(
    parameter int MAX_FRAMES = 64,
    parameter int PAGE_BITS  = 24
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [31:0]           i_reference_word,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic                       o_hit,
    output logic                       o_evicted_valid,
    output logic [PAGE_BITS-1:0]       o_evicted_page,
    output logic                       o_flushed,
    output logic signed [63:0]         o_acc_value,
    output logic [31:0]                o_fault_total,
    output logic [31:0]                o_write_total,
    output logic [31:0]                o_flush_total,
    input  wire logic                  i_cfg_we,
    input  wire logic [1:0]            i_cfg_index,
    input  wire logic [6:0]            i_cfg_data
);
    localparam int IW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CW = $clog2(MAX_FRAMES + 1) + 1;
    localparam int N  = MAX_FRAMES;

    plru_pkg::t_state r_state, n_state;

    logic       r_policy;
    logic [6:0] r_frames;
    logic [4:0] r_offset;

    logic [CW-1:0]        r_occ_cnt;
    logic [IW-1:0]        r_hand;
    logic signed [63:0]   r_acc;
    logic [31:0]          r_faults, r_writes, r_flushes;

    logic [N-1:0]         r_m, r_ltn, r_occ1h, r_last1h, r_n1h, r_hand1h;
    logic                 r_full;
    logic [PAGE_BITS-1:0] r_page;
    logic [1:0]           r_op;
    logic [5:0]           r_val;
    logic [CW-1:0]        r_occ;

    logic [PAGE_BITS-1:0]       c_page  [N];
    plru_pkg::t_slot_flags      c_flags [N];
    plru_pkg::t_cell_ctl        w_ctl   [N];

    logic [CW-1:0]        w_n, w_occ;
    logic [IW-1:0]        w_hand_eff;
    logic [PAGE_BITS-1:0] w_in_page;
    logic                 w_accept, w_go;

    logic [N-1:0] w_refv, w_dirtyv, w_f, w_gep, w_z, w_high, w_fh, w_fz, w_geh;
    logic [N-1:0] w_fill, w_shift, w_clr, w_setref, w_setdirty, w_v;
    logic         w_hit, w_ev, w_fl, w_wr, w_fill_dirty, w_occ_inc, w_hand_ld;
    logic [PAGE_BITS-1:0] w_ev_page;
    logic [IW-1:0]        w_v_idx;

    // lookup stage inputs
    always_comb begin
        if (r_frames == 7'd0) begin
            w_n = CW'(1);
        end else if (int'(r_frames) > MAX_FRAMES) begin
            w_n = CW'(MAX_FRAMES);
        end else begin
            w_n = CW'(r_frames);
        end
        w_occ      = (r_occ_cnt < w_n) ? r_occ_cnt : w_n;
        w_hand_eff = (CW'(r_hand) < w_n) ? r_hand : '0;
        w_in_page  = PAGE_BITS'(i_reference_word >> r_offset);
    end

    assign o_in_ready = (r_state == plru_pkg::ST_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_go       = (r_state == plru_pkg::ST_UPDATE) && (!o_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            for (int i = 0; i < N; i++) begin
                r_m[i]      <= c_flags[i].valid && (c_page[i] == w_in_page)
                               && (CW'(i) < w_occ);
                r_ltn[i]    <= CW'(i) < w_n;
                r_occ1h[i]  <= CW'(i) == w_occ;
                r_last1h[i] <= CW'(i) + CW'(1) == w_occ;
                r_n1h[i]    <= CW'(i) + CW'(1) == w_n;
                r_hand1h[i] <= IW'(i) == w_hand_eff;
            end
            r_full <= (w_occ == w_n);
            r_page <= w_in_page;
            r_op   <= 2'((i_reference_word & plru_pkg::OP_MASK) >> plru_pkg::OP_LSB);
            r_val  <= 6'(i_reference_word & plru_pkg::VALUE_MASK);
            r_occ  <= w_occ;
        end
    end

    // update stage
    always_comb begin
        for (int i = 0; i < N; i++) begin
            w_refv[i]   = c_flags[i].refb;
            w_dirtyv[i] = c_flags[i].dirty;
        end
        w_hit  = |r_m;
        w_f    = r_m & (~r_m + N'(1));
        w_gep  = ~(w_f - N'(1));
        w_z    = ~w_refv & r_ltn;
        w_geh  = ~(r_hand1h - N'(1));
        w_high = w_z & w_geh;
        w_fh   = w_high & (~w_high + N'(1));
        w_fz   = w_z & (~w_z + N'(1));
        w_wr   = (r_op == plru_pkg::OP_WRITE);

        w_fill = '0; w_shift = '0; w_clr = '0; w_setref = '0; w_setdirty = '0;
        w_v = '0; w_ev = 1'b0; w_fl = 1'b0; w_ev_page = '0;
        w_fill_dirty = w_wr; w_occ_inc = 1'b0; w_hand_ld = 1'b0;

        if (w_hit) begin
            if (r_policy == plru_pkg::POLICY_LRU) begin
                w_shift      = w_gep & (r_last1h - N'(1));
                w_fill       = r_last1h;
                w_fill_dirty = (|(w_f & w_dirtyv)) || w_wr;
            end else begin
                w_setref   = w_f;
                w_setdirty = w_wr ? w_f : '0;
            end
        end else if (!r_full) begin
            w_fill    = r_occ1h;
            w_occ_inc = 1'b1;
            w_v       = r_occ1h;
            w_hand_ld = (r_policy == plru_pkg::POLICY_CLOCK);
        end else begin
            w_ev = 1'b1;
            if (r_policy == plru_pkg::POLICY_LRU) begin
                w_shift = r_n1h - N'(1);
                w_v     = N'(1);
            end else begin
                if (|w_high) begin
                    w_v   = w_fh;
                    w_clr = w_geh & (w_fh - N'(1));
                end else if (|w_z) begin
                    w_v   = w_fz;
                    w_clr = (w_geh & r_ltn) | (w_fz - N'(1));
                end else begin
                    w_v   = r_hand1h;
                    w_clr = r_ltn;
                end
                w_hand_ld = 1'b1;
            end
            w_fill = (r_policy == plru_pkg::POLICY_LRU) ? r_n1h : w_v;
            for (int i = 0; i < N; i++) begin
                if (w_v[i]) begin
                    w_ev_page = w_ev_page | c_page[i];
                    w_fl      = w_fl | c_flags[i].dirty;
                end
            end
        end

        w_v_idx = '0;
        for (int i = 0; i < N; i++) begin
            if (w_v[i]) w_v_idx = w_v_idx | IW'(i);
        end

        for (int i = 0; i < N; i++) begin
            w_ctl[i].fill       = w_go && w_fill[i];
            w_ctl[i].fill_dirty = w_fill_dirty;
            w_ctl[i].shift      = w_go && w_shift[i];
            w_ctl[i].clr_ref    = w_go && w_clr[i];
            w_ctl[i].set_ref    = w_go && w_setref[i];
            w_ctl[i].set_dirty  = w_go && w_setdirty[i];
        end
    end

    for (genvar g = 0; g < N; g++) begin : g_cell
        if (g == N - 1) begin : g_end
            plru_cell #(.PAGE_BITS(PAGE_BITS)) u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctl      (w_ctl[g]),
                .i_fill_page(r_page),
                .i_nb_page  ('0),
                .i_nb_flags ('0),
                .o_page     (c_page[g]),
                .o_flags    (c_flags[g])
            );
        end else begin : g_mid
            plru_cell #(.PAGE_BITS(PAGE_BITS)) u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctl      (w_ctl[g]),
                .i_fill_page(r_page),
                .i_nb_page  (c_page[g+1]),
                .i_nb_flags (c_flags[g+1]),
                .o_page     (c_page[g]),
                .o_flags    (c_flags[g])
            );
        end
    end

    always_comb begin
        unique case (r_state)
            plru_pkg::ST_IDLE:   n_state = w_accept ? plru_pkg::ST_UPDATE : plru_pkg::ST_IDLE;
            plru_pkg::ST_UPDATE: n_state = w_go ? plru_pkg::ST_IDLE : plru_pkg::ST_UPDATE;
            default:             n_state = plru_pkg::ST_IDLE;
        endcase
    end

    logic signed [63:0] n_acc;
    always_comb begin
        case (r_op)
            plru_pkg::OP_ADD: n_acc = r_acc + 64'(r_val);
            plru_pkg::OP_SUB: n_acc = r_acc - 64'(r_val);
            default:          n_acc = r_acc;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_go) begin
            o_hit           <= w_hit;
            o_evicted_valid <= w_ev;
            o_evicted_page  <= w_ev_page;
            o_flushed       <= w_fl;
            o_acc_value     <= n_acc;
            o_fault_total   <= r_faults + 32'(!w_hit);
            o_write_total   <= r_writes + 32'(w_wr);
            o_flush_total   <= r_flushes + 32'(w_fl);
        end
        if (!i_rst_n) begin
            r_state     <= plru_pkg::ST_IDLE;
            r_policy    <= plru_pkg::POLICY_LRU;
            r_frames    <= 7'd64;
            r_offset    <= 5'd12;
            r_occ_cnt   <= '0;
            r_hand      <= '0;
            r_acc       <= '0;
            r_faults    <= '0;
            r_writes    <= '0;
            r_flushes   <= '0;
            o_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    plru_pkg::CFG_POLICY: r_policy <= i_cfg_data[0];
                    plru_pkg::CFG_FRAMES: r_frames <= i_cfg_data;
                    plru_pkg::CFG_OFFSET: r_offset <= i_cfg_data[4:0];
                    default:              r_policy <= r_policy;
                endcase
            end
            if (w_go) begin
                o_out_valid <= 1'b1;
                r_acc       <= n_acc;
                r_faults    <= r_faults + 32'(!w_hit);
                r_writes    <= r_writes + 32'(w_wr);
                r_flushes   <= r_flushes + 32'(w_fl);
                if (w_occ_inc) r_occ_cnt <= r_occ + CW'(1);
                if (w_hand_ld) r_hand <= w_v_idx;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    a_one_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_go |-> $onehot0(w_fill)) else $error("more than one slot filled");
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_occ_cnt) <= MAX_FRAMES) else $error("occupancy beyond frame count");
    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_hit && o_evicted_valid)) else $error("hit with eviction");
    a_fault_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_go |=> (r_faults - $past(r_faults)) == 32'(!$past(w_hit)))
        else $error("fault count step");
`endif
endmodule
`default_nettype wire

### hdl/plru_cell.sv
// One frame slot of the replacement chain: page, valid, ref and dirty marks.
// Depends on plru_pkg; takes its neighbour's contents on a shift.
`default_nettype none
module plru_cell #(
    parameter int PAGE_BITS = 24
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire plru_pkg::t_cell_ctl    i_ctl,
    input  wire logic [PAGE_BITS-1:0]   i_fill_page,
    input  wire logic [PAGE_BITS-1:0]   i_nb_page,
    input  wire plru_pkg::t_slot_flags  i_nb_flags,
    output logic [PAGE_BITS-1:0]        o_page,
    output plru_pkg::t_slot_flags       o_flags
);
    logic [PAGE_BITS-1:0]   r_page, n_page;
    plru_pkg::t_slot_flags  r_flags, n_flags;

    always_comb begin
        n_page  = r_page;
        n_flags = r_flags;
        if (i_ctl.fill) begin
            n_page        = i_fill_page;
            n_flags.valid = 1'b1;
            n_flags.refb  = 1'b1;
            n_flags.dirty = i_ctl.fill_dirty;
        end else if (i_ctl.shift) begin
            n_page  = i_nb_page;
            n_flags = i_nb_flags;
        end else begin
            if (i_ctl.clr_ref)   n_flags.refb  = 1'b0;
            if (i_ctl.set_ref)   n_flags.refb  = 1'b1;
            if (i_ctl.set_dirty) n_flags.dirty = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_page <= n_page;
        if (!i_rst_n) begin
            r_flags <= '0;
        end else begin
            r_flags <= n_flags;
        end
    end

    assign o_page  = r_page;
    assign o_flags = r_flags;
endmodule
`default_nettype wire

### test/page_replacement_lru_clock_unit_tb.sv
// Testbench for page_replacement_lru_clock_unit: LRU and second-chance clock replacement.
// Depends on plru_pkg; checks every result beat against a built-in page table predictor.
`default_nettype none
module page_replacement_lru_clock_unit_tb;

    typedef struct {
        logic        hit;
        logic        ev_valid;
        logic [23:0] ev_page;
        logic        flushed;
        logic [63:0] acc;
        logic [31:0] faults;
        logic [31:0] writes;
        logic [31:0] flushes;
    } t_outcome;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [31:0] i_reference_word = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic        o_hit;
    logic        o_evicted_valid;
    logic [23:0] o_evicted_page;
    logic        o_flushed;
    logic signed [63:0] o_acc_value;
    logic [31:0] o_fault_total;
    logic [31:0] o_write_total;
    logic [31:0] o_flush_total;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [6:0]  i_cfg_data = '0;

    page_replacement_lru_clock_unit dut (.*);

    always #10 i_clk = ~i_clk;

    // page table model
    logic [23:0] frame_page [64];
    bit          frame_vld [64];
    bit          frame_ref [64];
    bit          frame_dirty [64];
    int          occupied;
    int          hand;
    logic [63:0] acc;
    logic [31:0] fault_cnt, write_cnt, flush_cnt;
    logic        cur_policy;
    logic [6:0]  cur_frames;
    logic [4:0]  cur_offset;

    t_outcome    pending_results[$];
    int          errors = 0;
    int          cycle_cnt = 0;
    int          hold_req = 0;
    int          ready_mode = 0;

    function automatic void shift_frame(int dst, int src);
        frame_page[dst]  = frame_page[src];
        frame_vld[dst]   = frame_vld[src];
        frame_ref[dst]   = frame_ref[src];
        frame_dirty[dst] = frame_dirty[src];
    endfunction

    function automatic void load_frame(int pos, logic [23:0] pg);
        frame_page[pos]  = pg;
        frame_vld[pos]   = 1'b1;
        frame_ref[pos]   = 1'b1;
        frame_dirty[pos] = 1'b0;
    endfunction

    function automatic void predict_reference(logic [31:0] w);
        t_outcome       r;
        logic [23:0]    pg;
        plru_pkg::t_op  op;
        int             n, occ, pos, k;
        bit             all_set, d;
        pg  = 24'((w >> cur_offset) & 32'h00FF_FFFF);
        op  = plru_pkg::t_op'(w[7:6]);
        n   = (cur_frames == 0) ? 1 : (cur_frames > 64 ? 64 : int'(cur_frames));
        occ = occupied < n ? occupied : n;
        pos = 0;
        r   = '{default: '0};
        if (op == plru_pkg::OP_ADD) acc = acc + 64'(w[5:0]);
        else if (op == plru_pkg::OP_SUB) acc = acc - 64'(w[5:0]);
        for (int i = 0; i < occ; i++) begin
            if (frame_vld[i] && frame_page[i] == pg) begin
                r.hit = 1'b1;
                pos = i;
                break;
            end
        end
        if (r.hit) begin
            if (cur_policy == plru_pkg::POLICY_LRU) begin
                d = frame_dirty[pos];
                for (int i = pos; i + 1 < occ; i++) shift_frame(i, i + 1);
                pos = occ - 1;
                load_frame(pos, pg);
                frame_dirty[pos] = d;
            end else begin
                frame_ref[pos] = 1'b1;
            end
        end else begin
            fault_cnt++;
            if (occ < n) begin
                pos = occ;
                load_frame(pos, pg);
                occupied = occ + 1;
                if (cur_policy == plru_pkg::POLICY_CLOCK) hand = pos;
            end else if (cur_policy == plru_pkg::POLICY_LRU) begin
                r.ev_valid = 1'b1;
                r.ev_page  = frame_page[0];
                r.flushed  = frame_dirty[0];
                for (int i = 0; i + 1 < n; i++) shift_frame(i, i + 1);
                pos = n - 1;
                load_frame(pos, pg);
            end else begin
                k = hand < n ? hand : 0;
                all_set = 1'b1;
                for (int i = 0; i < n; i++) if (!frame_ref[i]) all_set = 1'b0;
                if (all_set) begin
                    for (int i = 0; i < n; i++) frame_ref[i] = 1'b0;
                end else begin
                    for (int i = 0; i < n; i++) begin
                        if (!frame_ref[k]) break;
                        frame_ref[k] = 1'b0;
                        k = (k + 1 == n) ? 0 : k + 1;
                    end
                end
                pos = k;
                r.ev_valid = 1'b1;
                r.ev_page  = frame_page[pos];
                r.flushed  = frame_dirty[pos];
                load_frame(pos, pg);
                hand = pos;
            end
        end
        if (r.flushed) flush_cnt++;
        if (op == plru_pkg::OP_WRITE) begin
            write_cnt++;
            frame_dirty[pos] = 1'b1;
        end
        r.acc = acc; r.faults = fault_cnt; r.writes = write_cnt; r.flushes = flush_cnt;
        pending_results.push_back(r);
    endfunction

    // all tasks below are entered just after a rising edge
    task automatic send_reference(input logic [31:0] w);
        i_in_valid <= 1'b1;
        i_reference_word <= w;
        do @(posedge i_clk); while (!o_in_ready);
        predict_reference(w);
    endtask

    task automatic idle_input(input int cycles);
        i_in_valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_reg(input plru_pkg::t_cfg_idx idx, input logic [6:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            plru_pkg::CFG_POLICY: cur_policy = data[0];
            plru_pkg::CFG_FRAMES: cur_frames = data;
            plru_pkg::CFG_OFFSET: cur_offset = data[4:0];
            default: ;
        endcase
    endtask

    task automatic configure(input logic pol, input logic [6:0] frames, input logic [4:0] off);
        drain_results();
        write_reg(plru_pkg::CFG_POLICY, {6'd0, pol});
        write_reg(plru_pkg::CFG_FRAMES, frames);
        write_reg(plru_pkg::CFG_OFFSET, {2'd0, off});
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] make_word(int pg, plru_pkg::t_op op);
        logic [31:0] low_mask;
        logic [31:0] w;
        low_mask = (32'h1 << cur_offset) - 1;
        w = ($urandom & low_mask) | (32'(pg) << cur_offset);
        if (cur_offset >= 8) w[7:6] = op;
        return w;
    endfunction

    task automatic send_bursts(input int count, input int pool);
        int burst;
        while (count > 0) begin
            burst = $urandom_range(1, 20);
            while (burst > 0 && count > 0) begin
                if ($urandom_range(0, 19) == 0) send_reference($urandom);
                else send_reference(make_word($urandom_range(0, pool),
                                              plru_pkg::t_op'($urandom_range(0, 3))));
                burst--;
                count--;
            end
            if ($urandom_range(0, 2) != 0) idle_input($urandom_range(1, 6));
        end
    endtask

    task automatic test_lru_directed();
        configure(plru_pkg::POLICY_LRU, 7'd3, 5'd12);
        send_reference(32'h0000_0000);
        send_reference(32'h0000_1080);
        send_reference(32'h0000_20BF);
        send_reference(32'h0000_0040);
        send_reference(32'h0000_307F);
        send_reference(32'h0000_4080);
        send_reference(32'hFFFF_FFFF);
        send_reference(32'hFFFF_F03F);
        send_reference(32'h0000_10C0);
    endtask

    task automatic test_clock_directed();
        configure(plru_pkg::POLICY_CLOCK, 7'd3, 5'd12);
        for (int i = 0; i < 8; i++) send_reference(make_word(i % 5, plru_pkg::OP_WRITE));
        configure(plru_pkg::POLICY_CLOCK, 7'd0, 5'd31);
        send_reference(32'h8000_0000);
        send_reference(32'h0000_0001);
        configure(plru_pkg::POLICY_CLOCK, 7'd127, 5'd0);
        send_reference(32'hFFFF_FFFF);
        send_reference(32'h1234_5678);
        configure(plru_pkg::POLICY_LRU, 7'd2, 5'd4);
        send_reference(32'h0000_00FF);
        send_reference(32'h0000_0010);
        send_reference(32'h0000_0020);
    endtask

    task automatic test_random_phases();
        logic [6:0] frames;
        logic [4:0] off;
        for (int ph = 0; ph < 10; ph++) begin
            case ($urandom_range(0, 5))
                0: frames = 7'd64;
                1: frames = 7'($urandom_range(65, 127));
                2: frames = 7'd0;
                default: frames = 7'($urandom_range(1, 8));
            endcase
            case ($urandom_range(0, 4))
                0: off = 5'd8;
                1: off = 5'd31;
                2: off = 5'($urandom_range(0, 7));
                default: off = 5'($urandom_range(9, 30));
            endcase
            ready_mode = $urandom_range(0, 2);
            configure(1'($urandom), frames, off);
            send_bursts(170, (frames > 64 ? 64 : int'(frames)) + 3);
        end
    endtask

    task automatic test_backpressure();
        configure(plru_pkg::POLICY_CLOCK, 7'd4, 5'd12);
        hold_req = 300;
        for (int i = 0; i < 40; i++) begin
            send_reference(make_word($urandom_range(0, 6), plru_pkg::OP_WRITE));
        end
        configure(plru_pkg::POLICY_LRU, 7'd64, 5'd12);
        send_bursts(60, 70);
    endtask

    task automatic test_drain_pause();
        send_bursts(30, 5);
        drain_results();
        send_bursts(30, 5);
    endtask

    always @(posedge i_clk) begin
        if (hold_req > 0) begin
            i_out_ready <= 1'b0;
            hold_req <= hold_req - 1;
        end else begin
            case (ready_mode)
                0: i_out_ready <= 1'b1;
                1: i_out_ready <= 1'($urandom);
                default: i_out_ready <= (cycle_cnt % 7) < 4;
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_outcome e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $error("result beat with nothing expected");
                errors++;
            end else begin
                e = pending_results.pop_front();
                if (o_hit !== e.hit) begin
                    $error("hit exp %0h got %0h", e.hit, o_hit); errors++;
                end
                if (o_evicted_valid !== e.ev_valid) begin
                    $error("evicted_valid exp %0h got %0h", e.ev_valid, o_evicted_valid);
                    errors++;
                end
                if (o_evicted_page !== e.ev_page) begin
                    $error("evicted_page exp %0h got %0h", e.ev_page, o_evicted_page);
                    errors++;
                end
                if (o_flushed !== e.flushed) begin
                    $error("flushed exp %0h got %0h", e.flushed, o_flushed); errors++;
                end
                if (o_acc_value !== e.acc) begin
                    $error("acc_value exp %0h got %0h", e.acc, o_acc_value); errors++;
                end
                if (o_fault_total !== e.faults) begin
                    $error("fault_total exp %0h got %0h", e.faults, o_fault_total); errors++;
                end
                if (o_write_total !== e.writes) begin
                    $error("write_total exp %0h got %0h", e.writes, o_write_total); errors++;
                end
                if (o_flush_total !== e.flushes) begin
                    $error("flush_total exp %0h got %0h", e.flushes, o_flush_total); errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > 300000) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < 64; i++) begin
            frame_vld[i] = 0; frame_ref[i] = 0; frame_dirty[i] = 0;
        end
        occupied = 0; hand = 0; acc = '0;
        fault_cnt = '0; write_cnt = '0; flush_cnt = '0;
        cur_policy = plru_pkg::POLICY_LRU; cur_frames = 7'd64; cur_offset = 5'd12;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_lru_directed();
        test_clock_directed();
        test_random_phases();
        test_backpressure();
        test_drain_pause();
        drain_results();
        if (errors == 0 && pending_results.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
`default_nettype wire
